>>> design/src_pkg.sv
// Shared types and constants for the sensor range calibrator.
// Used by src_ctrl, src_dp, sensor_range_calibrator and the testbench; no dependencies.

package src_pkg;

	localparam int SAMPLE_BITS   = 10;
	localparam int FRAC_BITS     = 15;
	localparam int MARGIN_BITS   = 10;
	localparam int LOW_BITS      = SAMPLE_BITS + 1;
	localparam int LEVEL_BITS    = FRAC_BITS + 1;
	localparam int CFG_DATA_BITS = (LOW_BITS > MARGIN_BITS) ? LOW_BITS : MARGIN_BITS;
	localparam int SUM_BITS      = ((SAMPLE_BITS > MARGIN_BITS) ? SAMPLE_BITS : MARGIN_BITS) + 1;
	localparam int CFG_IDX_BITS  = 2;
	localparam int STEP_BITS     = $clog2(FRAC_BITS + 1);

	localparam logic [LOW_BITS-1:0]    LOW_EMPTY    = {1'b1, {SAMPLE_BITS{1'b0}}};
	localparam logic [LEVEL_BITS-1:0]  LEVEL_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(5);
	localparam logic [LOW_BITS-1:0]    LOW_RESET    = '0;
	localparam logic [SAMPLE_BITS-1:0] HIGH_RESET   = SAMPLE_BITS'(1);
	localparam logic [SAMPLE_BITS-1:0] PEAK_RESET   = '0;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CALIB  = 1'b1
	} src_op_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PEAK_MARGIN = 2'd0,
		CFG_LOW_INIT    = 2'd1,
		CFG_HIGH_INIT   = 2'd2,
		CFG_PEAK_INIT   = 2'd3
	} src_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} src_state_t;

	typedef struct packed {
		src_op_t                opcode;
		logic [SAMPLE_BITS-1:0] sample;
		logic                   calibrate_on;
	} src_in_t;

	typedef struct packed {
		logic                   over_range;
		logic [LEVEL_BITS-1:0]  level;
		logic [LOW_BITS-1:0]    low_bound;
		logic [SAMPLE_BITS-1:0] high_bound;
		logic [SAMPLE_BITS-1:0] peak;
	} src_out_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic prep;
		logic div_step;
		logic out_load;
	} src_cmd_t;

	typedef struct packed {
		logic is_calib;
		logic over;
		logic no_result;
		logic level_zero;
		logic div_last;
	} src_status_t;

endpackage

>>> design/sensor_range_calibrator.sv
// Sensor range calibrator: peak tracking, calibrated thresholds and inverted level.
// Top level joining src_ctrl and src_dp; uses src_pkg.
//
// A sample passes, in order, through capture, an update of peak and thresholds,
// a clamp, 16 steps of the restoring divider that forms the Q1.15 level, and a
// load of the output register, which waits while that register is still full;
// in_ready stays low until the item is through. An over-range sample or one
// with low above high skips the divider; a calibrate command or a sample with
// equal thresholds gives no result. The result waits in the output register
// while the next item is taken in.

module sensor_range_calibrator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [src_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [src_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  src_pkg::src_in_t                  in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output src_pkg::src_out_t                 out_item
);

	src_pkg::src_cmd_t    cmd;
	src_pkg::src_status_t status;

	src_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	src_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_item  (out_item)
	);

	a_over_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.over_range |-> out_item.level == '0)
		else $error("over-range result with nonzero level");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.level <= src_pkg::LEVEL_ONE)
		else $error("level above one");

	a_no_equal_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.over_range |->
			out_item.low_bound != {1'b0, out_item.high_bound})
		else $error("result with equal thresholds");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

endmodule

>>> design/src_ctrl.sv
// Controller state machine for the sensor range calibrator.
// Sequences capture, evaluation, divider steps and the output transfer; uses src_pkg.

module src_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  src_pkg::src_status_t  status,
	output src_pkg::src_cmd_t     cmd
);

	src_pkg::src_state_t state_q, state_d;
	logic                out_valid_q;
	logic                out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= src_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			src_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = src_pkg::ST_EVAL;
				end
			end
			src_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				if (status.is_calib) begin
					state_d = src_pkg::ST_IDLE;
				end else if (status.over) begin
					state_d = src_pkg::ST_DONE;
				end else begin
					state_d = src_pkg::ST_PREP;
				end
			end
			src_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				if (status.no_result) begin
					state_d = src_pkg::ST_IDLE;
				end else if (status.level_zero) begin
					state_d = src_pkg::ST_DONE;
				end else begin
					state_d = src_pkg::ST_DIV;
				end
			end
			src_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = src_pkg::ST_DONE;
				end
			end
			src_pkg::ST_DONE: begin
				cmd.out_load = out_free;
				if (out_free) begin
					state_d = src_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = src_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/src_dp.sv
// Datapath for the sensor range calibrator: thresholds, peak, calibration backup,
// clamp, restoring divider and result register. Uses src_pkg.

module src_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [src_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [src_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  src_pkg::src_in_t                      in_item,
	input  src_pkg::src_cmd_t                     cmd,
	output src_pkg::src_status_t                  status,
	output src_pkg::src_out_t                     out_item
);

	localparam int SB = src_pkg::SAMPLE_BITS;
	localparam int LB = src_pkg::LOW_BITS;
	localparam int VB = src_pkg::LEVEL_BITS;
	localparam int SM = src_pkg::SUM_BITS;

	logic [src_pkg::MARGIN_BITS-1:0] margin_q;
	logic                            calib_q;
	logic [SB-1:0]                   peak_q;
	logic [LB-1:0]                   lo_q;
	logic [SB-1:0]                   hi_q;
	logic [LB-1:0]                   lo_bk_q;
	logic [SB-1:0]                   hi_bk_q;

	src_pkg::src_in_t                item_q;
	logic                            over_q;
	logic [VB-1:0]                   level_q;
	logic [SB-1:0]                   rem_q;
	logic [SB-1:0]                   div_q;
	logic [VB-1:0]                   quo_q;
	logic [src_pkg::STEP_BITS-1:0]   step_q;
	src_pkg::src_out_t               res_q;

	logic [SB-1:0] n;
	logic [LB-1:0] n_ext;
	logic [SB-1:0] peak_new;
	logic          over;
	logic [LB-1:0] lo_min;
	logic [SB-1:0] hi_max;
	logic [LB-1:0] lo_rest;
	logic [SB-1:0] hi_rest;
	logic [LB-1:0] hi_ext;
	logic [LB-1:0] clamp_lo;
	logic [LB-1:0] clamp;
	logic [LB-1:0] num;
	logic [LB-1:0] den;
	logic [SB:0]   trial;
	logic          ge;
	logic [SB:0]   trial_sub;
	logic [VB-1:0] quo_next;

	assign n        = item_q.sample;
	assign n_ext    = {1'b0, n};
	assign hi_ext   = {1'b0, hi_q};
	assign peak_new = (n > peak_q) ? n : peak_q;
	assign over     = (SM'(n) + SM'(margin_q)) > SM'(peak_new);
	assign lo_min   = (n_ext < lo_q) ? n_ext : lo_q;
	assign hi_max   = (n > hi_q) ? n : hi_q;
	assign lo_rest  = (lo_q == src_pkg::LOW_EMPTY) ? lo_bk_q : lo_q;
	assign hi_rest  = (hi_q == '0) ? hi_bk_q : hi_q;

	assign clamp_lo = (n_ext < lo_q) ? lo_q : n_ext;
	assign clamp    = (clamp_lo > hi_ext) ? hi_ext : clamp_lo;
	assign num      = clamp - lo_q;
	assign den      = hi_ext - lo_q;

	assign trial     = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign ge        = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};
	assign quo_next  = {quo_q[VB-2:0], ge};

	assign status.is_calib   = (item_q.opcode == src_pkg::OP_CALIB);
	assign status.over       = over;
	assign status.no_result  = (lo_q == hi_ext);
	assign status.level_zero = (lo_q > hi_ext);
	assign status.div_last   = (step_q == src_pkg::STEP_BITS'(src_pkg::FRAC_BITS));

	assign out_item = res_q;

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= src_pkg::MARGIN_RESET;
			calib_q  <= 1'b0;
			peak_q   <= src_pkg::PEAK_RESET;
			lo_q     <= src_pkg::LOW_RESET;
			hi_q     <= src_pkg::HIGH_RESET;
			lo_bk_q  <= '0;
			hi_bk_q  <= '0;
		end else if (cfg_we) begin
			case (src_pkg::src_cfg_idx_t'(cfg_index))
				src_pkg::CFG_PEAK_MARGIN: margin_q <= cfg_data[src_pkg::MARGIN_BITS-1:0];
				src_pkg::CFG_LOW_INIT:    lo_q     <= cfg_data[LB-1:0];
				src_pkg::CFG_HIGH_INIT:   hi_q     <= cfg_data[SB-1:0];
				src_pkg::CFG_PEAK_INIT:   peak_q   <= cfg_data[SB-1:0];
				default: ;
			endcase
		end else if (cmd.eval) begin
			if (item_q.opcode == src_pkg::OP_CALIB) begin
				if (item_q.calibrate_on != calib_q) begin
					calib_q <= item_q.calibrate_on;
					if (item_q.calibrate_on) begin
						lo_bk_q <= lo_q;
						hi_bk_q <= hi_q;
						lo_q    <= src_pkg::LOW_EMPTY;
						hi_q    <= '0;
					end else if ({1'b0, hi_rest} == lo_rest) begin
						lo_q <= lo_bk_q;
						hi_q <= hi_bk_q;
					end else begin
						lo_q <= lo_rest;
						hi_q <= hi_rest;
					end
				end
			end else begin
				peak_q <= peak_new;
				if (!over && calib_q) begin
					lo_q <= lo_min;
					hi_q <= hi_max;
				end
			end
		end
	end

	// item, divider and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
		if (cmd.eval) begin
			over_q  <= over;
			level_q <= '0;
		end
		if (cmd.prep) begin
			rem_q  <= num[SB-1:0];
			div_q  <= den[SB-1:0];
			quo_q  <= '0;
			step_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? trial_sub[SB-1:0] : trial[SB-1:0];
			quo_q  <= quo_next;
			step_q <= step_q + 1'b1;
			if (status.div_last) begin
				level_q <= src_pkg::LEVEL_ONE - quo_next;
			end
		end
		if (cmd.out_load) begin
			res_q.over_range <= over_q;
			res_q.level      <= level_q;
			res_q.low_bound  <= lo_q;
			res_q.high_bound <= hi_q;
			res_q.peak       <= peak_q;
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench for sensor_range_calibrator: a directed table, then random phases of samples
// and calibration sessions under several idle/stall mixes, checked against a local predictor.
// Depends on src_pkg and the sensor_range_calibrator RTL.

module tb;
	import src_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 24;
	localparam int PHASE_ITEMS    = 78;
	localparam int NUM_PHASES     = 8;
	localparam int NUM_ROWS       = 26;
	localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;

	typedef struct {
		src_in_t  item;
		bit       fixed;
		src_out_t want;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	src_in_t                  in_item;
	logic                     out_valid;
	logic                     out_ready;
	src_out_t                 out_item;

	logic                   in_calib;
	logic [MARGIN_BITS-1:0] pk_margin;
	logic [SAMPLE_BITS-1:0] run_peak;
	logic [LOW_BITS-1:0]    lo_thr;
	logic [SAMPLE_BITS-1:0] hi_thr;
	logic [LOW_BITS-1:0]    lo_saved;
	logic [SAMPLE_BITS-1:0] hi_saved;

	src_out_t due_levels [$];
	src_out_t head;
	dir_row_t dir_rows [NUM_ROWS];
	int       mismatches;
	int       quiet_cycles;
	int       send_idle_pct;
	int       recv_stall_pct;

	sensor_range_calibrator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always #1 clk = ~clk;

	function automatic bit predict_level(input src_in_t it, output src_out_t res);
		int n;
		int lo;
		int hi;
		int q;
		bit over;
		res = '0;
		if (it.opcode == OP_CALIB) begin
			if (it.calibrate_on != in_calib) begin
				in_calib = it.calibrate_on;
				if (in_calib) begin
					lo_saved = lo_thr;
					hi_saved = hi_thr;
					lo_thr = LOW_EMPTY;
					hi_thr = '0;
				end else begin
					if (lo_thr == LOW_EMPTY)
						lo_thr = lo_saved;
					if (hi_thr == '0)
						hi_thr = hi_saved;
					if (hi_thr == lo_thr) begin
						lo_thr = lo_saved;
						hi_thr = hi_saved;
					end
				end
			end
			return 1'b0;
		end
		n = it.sample;
		if (n > run_peak)
			run_peak = it.sample;
		over = (n + pk_margin) > run_peak;
		res.over_range = over;
		if (!over) begin
			if (in_calib) begin
				if (n < lo_thr)
					lo_thr = LOW_BITS'(n);
				if (n > hi_thr)
					hi_thr = it.sample;
			end
			lo = lo_thr;
			hi = hi_thr;
			if (n < lo)
				n = lo;
			if (n > hi)
				n = hi;
			if (lo == hi)
				return 1'b0;
			if (lo < hi) begin
				q = ((n - lo) << FRAC_BITS) / (hi - lo);
				res.level = LEVEL_BITS'(int'(LEVEL_ONE) - q);
			end
		end
		res.low_bound = lo_thr;
		res.high_bound = hi_thr;
		res.peak = run_peak;
		return 1'b1;
	endfunction

	function automatic dir_row_t dir_row(src_op_t op, int smp, bit on, bit fixed = 0,
			bit ov = 0, int lvl = 0, int lo = 0, int hi = 0, int pk = 0);
		dir_row_t r;
		r.item.opcode = op;
		r.item.sample = SAMPLE_BITS'(smp);
		r.item.calibrate_on = on;
		r.fixed = fixed;
		r.want.over_range = ov;
		r.want.level = LEVEL_BITS'(lvl);
		r.want.low_bound = LOW_BITS'(lo);
		r.want.high_bound = SAMPLE_BITS'(hi);
		r.want.peak = SAMPLE_BITS'(pk);
		return r;
	endfunction

	function automatic src_in_t calib_cmd(bit on);
		src_in_t it;
		it.opcode = OP_CALIB;
		it.sample = SAMPLE_BITS'($urandom);
		it.calibrate_on = on;
		return it;
	endfunction

	function automatic src_in_t rand_sample();
		src_in_t it;
		int v;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = SAMPLE_MAX;
			2: begin
				v = int'(run_peak) - int'(pk_margin) + int'($urandom_range(0, 2)) - 1;
				if (v < 0)
					v = 0;
				if (v > SAMPLE_MAX)
					v = SAMPLE_MAX;
			end
			default: v = $urandom_range(0, SAMPLE_MAX);
		endcase
		it.opcode = OP_SAMPLE;
		it.sample = SAMPLE_BITS'(v);
		it.calibrate_on = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic report_mismatch(input string what, input src_out_t want, input src_out_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected over=%0d level=%0d lo=%0d hi=%0d peak=%0d, got over=%0d level=%0d lo=%0d hi=%0d peak=%0d",
				what, want.over_range, want.level, want.low_bound, want.high_bound, want.peak,
				got.over_range, got.level, got.low_bound, got.high_bound, got.peak);
	endtask

	task automatic send_item(input src_in_t it, input bit fixed, input src_out_t want);
		src_out_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		if (predict_level(it, res))
			due_levels.push_back(fixed ? want : res);
		@(negedge clk);
	endtask

	task automatic drain(input int extra);
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (due_levels.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input src_cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_PEAK_MARGIN: pk_margin = val[MARGIN_BITS-1:0];
			CFG_LOW_INIT:    lo_thr = val[LOW_BITS-1:0];
			CFG_HIGH_INIT:   hi_thr = val[SAMPLE_BITS-1:0];
			CFG_PEAK_INIT:   run_peak = val[SAMPLE_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_levels.size() == 0) begin
				report_mismatch("unexpected transfer", '0, out_item);
			end else begin
				head = due_levels.pop_front();
				if (out_item.over_range !== head.over_range || out_item.level !== head.level
						|| out_item.low_bound !== head.low_bound
						|| out_item.high_bound !== head.high_bound
						|| out_item.peak !== head.peak)
					report_mismatch("result mismatch", head, out_item);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("sensor_range_calibrator: mismatch");
			$finish;
		end
	end

	initial begin
		src_out_t none;
		int sent;
		int burst;
		bit paused;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PEAK_MARGIN;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		none = '0;
		mismatches = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		in_calib = 1'b0;
		pk_margin = MARGIN_RESET;
		run_peak = PEAK_RESET;
		lo_thr = LOW_RESET;
		hi_thr = HIGH_RESET;
		lo_saved = '0;
		hi_saved = '0;

		dir_rows = '{
			dir_row(OP_SAMPLE, 0, 0, 1, 1, 0, 0, 1, 0),
			dir_row(OP_SAMPLE, 1023, 1, 1, 1, 0, 0, 1, 1023),
			dir_row(OP_SAMPLE, 0, 0, 1, 0, 32768, 0, 1, 1023),
			dir_row(OP_SAMPLE, 500, 1, 1, 0, 0, 0, 1, 1023),
			dir_row(OP_SAMPLE, 1018, 0, 1, 0, 0, 0, 1, 1023),
			dir_row(OP_SAMPLE, 1019, 0, 1, 1, 0, 0, 1, 1023),
			dir_row(OP_CALIB, 1023, 1),
			dir_row(OP_CALIB, 341, 1),
			dir_row(OP_SAMPLE, 300, 0),
			dir_row(OP_SAMPLE, 700, 1),
			dir_row(OP_SAMPLE, 400, 0),
			dir_row(OP_SAMPLE, 1023, 0, 1, 1, 0, 300, 700, 1023),
			dir_row(OP_CALIB, 682, 0),
			dir_row(OP_CALIB, 0, 0),
			dir_row(OP_SAMPLE, 200, 0, 1, 0, 32768, 300, 700, 1023),
			dir_row(OP_SAMPLE, 1000, 1, 1, 0, 0, 300, 700, 1023),
			dir_row(OP_CALIB, 512, 1),
			dir_row(OP_CALIB, 1, 0),
			dir_row(OP_SAMPLE, 550, 0),
			dir_row(OP_CALIB, 2, 1),
			dir_row(OP_SAMPLE, 600, 0),
			dir_row(OP_CALIB, 4, 0),
			dir_row(OP_CALIB, 8, 1),
			dir_row(OP_SAMPLE, 0, 1),
			dir_row(OP_CALIB, 16, 0),
			dir_row(OP_SAMPLE, 350, 1)
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < NUM_ROWS; r++)
			send_item(dir_rows[r].item, dir_rows[r].fixed, dir_rows[r].want);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain(SETTLE_CYCLES);
			case (phase)
				0: begin
					write_reg(CFG_PEAK_MARGIN, 0);
					write_reg(CFG_LOW_INIT, 0);
					write_reg(CFG_HIGH_INIT, 1023);
					write_reg(CFG_PEAK_INIT, 0);
				end
				1: begin
					write_reg(CFG_PEAK_MARGIN, 1023);
					write_reg(CFG_LOW_INIT, 1024);
					write_reg(CFG_HIGH_INIT, 0);
					write_reg(CFG_PEAK_INIT, 1023);
				end
				2: begin
					write_reg(CFG_PEAK_MARGIN, 20);
					write_reg(CFG_LOW_INIT, 512);
					write_reg(CFG_HIGH_INIT, 512);
					write_reg(CFG_PEAK_INIT, 1023);
				end
				3: begin
					write_reg(CFG_PEAK_MARGIN, 5);
					write_reg(CFG_LOW_INIT, 100);
					write_reg(CFG_HIGH_INIT, 900);
					write_reg(CFG_PEAK_INIT, 1023);
				end
				default: begin
					write_reg(CFG_PEAK_MARGIN, CFG_DATA_BITS'($urandom));
					write_reg(CFG_LOW_INIT, CFG_DATA_BITS'($urandom));
					write_reg(CFG_HIGH_INIT, CFG_DATA_BITS'($urandom));
					write_reg(CFG_PEAK_INIT, CFG_DATA_BITS'($urandom));
				end
			endcase
			cfg_we <= 1'b0;

			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 52;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 52;
				end
				default: begin
					send_idle_pct = 6;
					recv_stall_pct = 6;
				end
			endcase

			sent = 0;
			paused = 1'b0;
			while (sent < PHASE_ITEMS) begin
				if (!paused && sent >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					drain(0);
				end
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						burst = $urandom_range(2, 10);
						send_item(calib_cmd(1'b1), 1'b0, none);
						repeat (burst) send_item(rand_sample(), 1'b0, none);
						send_item(calib_cmd(1'b0), 1'b0, none);
						sent += burst + 2;
					end
					3: begin
						send_item(calib_cmd(1'($urandom_range(0, 1))), 1'b0, none);
						sent++;
					end
					default: begin
						send_item(rand_sample(), 1'b0, none);
						sent++;
					end
				endcase
			end
		end

		drain(SETTLE_CYCLES);
		if (mismatches == 0 && due_levels.size() == 0)
			$display("sensor_range_calibrator: match");
		else
			$display("sensor_range_calibrator: mismatch");
		$finish;
	end

endmodule

>>> sensor_range_calibrator.f
design/src_pkg.sv
design/src_ctrl.sv
design/src_dp.sv
design/sensor_range_calibrator.sv
test/tb.sv
